/* rtl/rrtt_pkg.sv */
// Package for the round-robin task table.
// Request, task state, kill status and sequencer state codes, slot entry type, field widths.
// No dependencies.
package rrtt_pkg;

  // Default table depth
  localparam int unsigned NUM_SLOTS_DEF = 8;

  // Field widths of the request and result ports
  localparam int unsigned REQ_W   = 3;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned KILL_W  = 2;
  localparam int unsigned STATE_W = 3;

  // Width of one stored slot entry: valid bit and task state
  localparam int unsigned ENT_W = 1 + STATE_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK     = 3'd0,
    REQ_CREATE   = 3'd1,
    REQ_KILL     = 3'd2,
    REQ_KILL_CUR = 3'd3,
    REQ_FIND     = 3'd4,
    REQ_BLOCK    = 3'd5,
    REQ_WAKE     = 3'd6,
    REQ_READ     = 3'd7
  } req_e;

  typedef enum logic [STATE_W-1:0] {
    ST_READY       = 3'd0,
    ST_RUNNING     = 3'd1,
    ST_BLOCKED     = 3'd2,
    ST_SUSPEND     = 3'd3,
    ST_KILLED      = 3'd4,
    ST_NOT_CREATED = 3'd5
  } task_state_e;

  typedef enum logic [KILL_W-1:0] {
    KS_KILLED  = 2'd0,
    KS_REFUSED = 2'd1,
    KS_ABSENT  = 2'd2
  } kill_status_e;

  typedef struct packed {
    logic               valid;
    logic [STATE_W-1:0] state;
  } slot_entry_t;

  // Sequencer states
  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_SLOT_CHK,
    SQ_PREV_CHK,
    SQ_SCAN,
    SQ_NEW_WR,
    SQ_OLD_WR,
    SQ_FIN
  } seq_state_e;

endpackage

/* rtl/rrtt_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// Read of an address written in the same cycle returns the old data.
// No dependencies.
module rrtt_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/round_robin_task_table.sv */
// Top level of the round-robin task table.
// Depends on rrtt_pkg and rrtt_ram (slot entry store).
//
//  channel   | handshake           | payload
//  ----------+---------------------+---------------------------------------------
//  request   | start_i, busy_o     | req_type_i, slot_i
//  result    | done_o (one cycle)  | current_slot_o, kill_status_o, free_found_o,
//            |                     | free_slot_o, slot_state_o, sched_error_o
//
// A request is taken when start_i is high and busy_o low. Create and refused
// requests go straight to the finish state, single-slot reads/updates pass a slot
// check, and a find or schedule scans the table, reading one entry a cycle from the
// single read port of the slot RAM. busy_o stays high until done_o has pulsed.
// The result holds from done_o until a new request is taken and is never stalled.
// No clearing pass after reset: per-entry written flags stand in for reset values.
module round_robin_task_table #(
  parameter int unsigned NUM_SLOTS = rrtt_pkg::NUM_SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [rrtt_pkg::REQ_W-1:0]  req_type_i,
  input  logic [rrtt_pkg::SLOT_W-1:0] slot_i,
  output logic                        done_o,
  output logic [rrtt_pkg::SLOT_W-1:0] current_slot_o,
  output logic [rrtt_pkg::KILL_W-1:0] kill_status_o,
  output logic                        free_found_o,
  output logic [rrtt_pkg::SLOT_W-1:0] free_slot_o,
  output logic [rrtt_pkg::STATE_W-1:0] slot_state_o,
  output logic                        sched_error_o
);
  import rrtt_pkg::*;

  localparam int unsigned SW = $clog2(NUM_SLOTS);
  localparam int unsigned CW = $clog2(NUM_SLOTS + 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);
  localparam logic [CW-1:0] SCAN_LEN  = CW'(NUM_SLOTS);

  seq_state_e state_q, state_d;
  req_e       req_q, req_d, req_in;

  logic [SW-1:0] running_q, running_d;
  logic [SW-1:0] prev_q, prev_d;
  logic          prev_run_q, prev_run_d;
  logic [SW-1:0] cand_q, cand_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          live_q, live_d;
  logic [SW-1:0] hit_q, hit_d;
  logic [SW-1:0] rd_addr_q, rd_addr_d;
  logic [NUM_SLOTS-1:0] written_q, written_d;

  logic [KILL_W-1:0]  res_kill_q, res_kill_d;
  logic               res_found_q, res_found_d;
  logic [SLOT_W-1:0]  res_free_q, res_free_d;
  logic [STATE_W-1:0] res_state_q, res_state_d;
  logic               res_err_q, res_err_d;

  // RAM port signals
  logic          ram_we, ram_re;
  logic [SW-1:0] ram_waddr, ram_raddr;
  slot_entry_t   ram_wdata;
  logic [ENT_W-1:0] ram_rdata;

  slot_entry_t   rd_ent;
  logic [SW-1:0] slot_idx;
  logic          in_range;
  logic          find_mode;
  logic          issuing;
  logic          scan_hit;
  logic          scan_miss;

  // Slot entry store
  rrtt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Request decode
  assign req_in   = req_e'(req_type_i);
  assign slot_idx = SW'(slot_i);
  assign in_range = int'(slot_i) < NUM_SLOTS;

  // Entry not yet written reads as its reset value
  always_comb begin
    if (written_q[rd_addr_q]) begin
      rd_ent = slot_entry_t'(ram_rdata);
    end else begin
      rd_ent.valid = (rd_addr_q == '0);
      rd_ent.state = ST_READY;
    end
  end

  // Scan control: one read issued per cycle, checked in the cycle after it is issued
  assign find_mode = (req_q == REQ_FIND);
  assign issuing   = (state_q == SQ_SCAN) && (cnt_q != SCAN_LEN);
  assign scan_hit  = live_q && (find_mode ? !rd_ent.valid
                                          : (rd_ent.valid && rd_ent.state == ST_READY));
  assign scan_miss = !live_q && !issuing;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SQ_IDLE: begin
        if (start_i) begin
          unique case (req_in)
            REQ_TICK:     state_d = SQ_PREV_CHK;
            REQ_CREATE:   state_d = SQ_FIN;
            REQ_KILL:     state_d = (slot_i != '0 && in_range) ? SQ_SLOT_CHK : SQ_FIN;
            REQ_KILL_CUR: state_d = (running_q == '0) ? SQ_FIN : SQ_SCAN;
            REQ_FIND:     state_d = SQ_SCAN;
            REQ_BLOCK, REQ_WAKE, REQ_READ: begin
              state_d = in_range ? SQ_SLOT_CHK : SQ_FIN;
            end
            default:      state_d = SQ_FIN;
          endcase
        end
      end
      SQ_SLOT_CHK: state_d = SQ_FIN;
      SQ_PREV_CHK: state_d = SQ_SCAN;
      SQ_SCAN: begin
        if (scan_hit) begin
          if (find_mode || rd_addr_q == running_q) begin
            state_d = SQ_FIN;
          end else begin
            state_d = SQ_NEW_WR;
          end
        end else if (scan_miss) begin
          state_d = SQ_FIN;
        end
      end
      SQ_NEW_WR: state_d = prev_run_q ? SQ_OLD_WR : SQ_FIN;
      SQ_OLD_WR: state_d = SQ_FIN;
      SQ_FIN:    state_d = SQ_IDLE;
      default:   state_d = SQ_IDLE;
    endcase
  end

  // Datapath, RAM accesses and result updates
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    req_d       = req_q;
    running_d   = running_q;
    prev_d      = prev_q;
    prev_run_d  = prev_run_q;
    cand_d      = cand_q;
    cnt_d       = cnt_q;
    live_d      = live_q;
    hit_d       = hit_q;
    res_kill_d  = res_kill_q;
    res_found_d = res_found_q;
    res_free_d  = res_free_q;
    res_state_d = res_state_q;
    res_err_d   = res_err_q;

    unique case (state_q)
      SQ_IDLE: begin
        if (start_i) begin
          req_d       = req_in;
          res_kill_d  = KS_KILLED;
          res_found_d = 1'b0;
          res_free_d  = '0;
          res_state_d = ST_READY;
          res_err_d   = 1'b0;
          cnt_d       = '0;
          live_d      = 1'b0;
          unique case (req_in)
            REQ_TICK: begin
              ram_re    = 1'b1;
              ram_raddr = running_q;
            end
            REQ_CREATE: begin
              if (in_range) begin
                ram_we          = 1'b1;
                ram_waddr       = slot_idx;
                ram_wdata.valid = 1'b1;
                ram_wdata.state = ST_READY;
              end
            end
            REQ_KILL: begin
              if (slot_i == '0) begin
                res_kill_d = KS_REFUSED;
              end else if (!in_range) begin
                res_kill_d = KS_ABSENT;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = slot_idx;
              end
            end
            REQ_KILL_CUR: begin
              if (running_q == '0) begin
                res_kill_d = KS_REFUSED;
              end else begin
                // kill the running slot, then schedule from it
                ram_we          = 1'b1;
                ram_waddr       = running_q;
                ram_wdata.valid = 1'b0;
                ram_wdata.state = ST_KILLED;
                prev_d          = running_q;
                prev_run_d      = 1'b0;
                cand_d          = (running_q == LAST_SLOT) ? '0 : running_q + 1'b1;
              end
            end
            REQ_FIND: begin
              cand_d = '0;
            end
            REQ_BLOCK, REQ_WAKE: begin
              if (in_range) begin
                ram_re    = 1'b1;
                ram_raddr = slot_idx;
              end
            end
            REQ_READ: begin
              if (in_range) begin
                ram_re    = 1'b1;
                ram_raddr = slot_idx;
              end else begin
                res_state_d = ST_NOT_CREATED;
              end
            end
            default: ;
          endcase
        end
      end

      // read-modify-write of the addressed slot (read only for a state read or a kill of an invalid slot)
      SQ_SLOT_CHK: begin
        unique case (req_q)
          REQ_KILL: begin
            if (rd_ent.valid) begin
              ram_we          = 1'b1;
              ram_waddr       = rd_addr_q;
              ram_wdata.valid = 1'b0;
              ram_wdata.state = ST_KILLED;
            end else begin
              res_kill_d = KS_ABSENT;
            end
          end
          REQ_BLOCK: begin
            ram_we          = 1'b1;
            ram_waddr       = rd_addr_q;
            ram_wdata.valid = rd_ent.valid;
            ram_wdata.state = ST_BLOCKED;
          end
          REQ_WAKE: begin
            ram_we          = 1'b1;
            ram_waddr       = rd_addr_q;
            ram_wdata.valid = rd_ent.valid;
            ram_wdata.state = ST_READY;
          end
          REQ_READ: begin
            res_state_d = rd_ent.state;
          end
          default: ;
        endcase
      end

      // note whether the current slot is running, start the round-robin scan
      SQ_PREV_CHK: begin
        prev_d     = running_q;
        prev_run_d = rd_ent.valid && (rd_ent.state == ST_RUNNING);
        cand_d     = (running_q == LAST_SLOT) ? '0 : running_q + 1'b1;
        cnt_d      = '0;
        live_d     = 1'b0;
      end

      SQ_SCAN: begin
        live_d = issuing;
        if (issuing) begin
          ram_re    = 1'b1;
          ram_raddr = cand_q;
          cand_d    = (cand_q == LAST_SLOT) ? '0 : cand_q + 1'b1;
          cnt_d     = cnt_q + 1'b1;
        end
        if (scan_hit) begin
          if (find_mode) begin
            res_found_d = 1'b1;
            res_free_d  = SLOT_W'(rd_addr_q);
          end else begin
            hit_d = rd_addr_q;
          end
        end else if (scan_miss && !find_mode) begin
          res_err_d = 1'b1;
        end
      end

      SQ_NEW_WR: begin
        ram_we          = 1'b1;
        ram_waddr       = hit_q;
        ram_wdata.valid = 1'b1;
        ram_wdata.state = ST_RUNNING;
        running_d       = hit_q;
      end

      // a running slot is always valid, so it returns to valid and ready
      SQ_OLD_WR: begin
        ram_we          = 1'b1;
        ram_waddr       = prev_q;
        ram_wdata.valid = 1'b1;
        ram_wdata.state = ST_READY;
      end

      SQ_FIN: ;
      default: ;
    endcase
  end

  // Read address pipe and written flags follow the RAM port
  always_comb begin
    rd_addr_d = rd_addr_q;
    if (ram_re) begin
      rd_addr_d = ram_raddr;
    end
    written_d = written_q;
    if (ram_we) begin
      written_d[ram_waddr] = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SQ_IDLE;
      running_q <= '0;
      written_q <= '0;
      live_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      running_q <= running_d;
      written_q <= written_d;
      live_q    <= live_d;
      cnt_q     <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    prev_q      <= prev_d;
    prev_run_q  <= prev_run_d;
    cand_q      <= cand_d;
    hit_q       <= hit_d;
    rd_addr_q   <= rd_addr_d;
    res_kill_q  <= res_kill_d;
    res_found_q <= res_found_d;
    res_free_q  <= res_free_d;
    res_state_q <= res_state_d;
    res_err_q   <= res_err_d;
  end

  // Ports
  assign busy_o         = (state_q != SQ_IDLE);
  assign done_o         = (state_q == SQ_FIN);
  assign current_slot_o = SLOT_W'(running_q);
  assign kill_status_o  = res_kill_q;
  assign free_found_o   = res_found_q;
  assign free_slot_o    = res_free_q;
  assign slot_state_o   = res_state_q;
  assign sched_error_o  = res_err_q;

endmodule

/* rtl/rrtt_checker.sv */
// Port-level checks for the round-robin task table, bound to the top level.
// Depends on rrtt_pkg and round_robin_task_table.
module rrtt_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic [rrtt_pkg::REQ_W-1:0]   req_type_i,
  input logic [rrtt_pkg::SLOT_W-1:0]  slot_i,
  input logic                         done_o,
  input logic [rrtt_pkg::SLOT_W-1:0]  current_slot_o,
  input logic [rrtt_pkg::KILL_W-1:0]  kill_status_o,
  input logic                         free_found_o,
  input logic [rrtt_pkg::SLOT_W-1:0]  free_slot_o,
  input logic [rrtt_pkg::STATE_W-1:0] slot_state_o,
  input logic                         sched_error_o
);
  import rrtt_pkg::*;

  // An accepted request keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted request did not raise busy");

  // After a result the block is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o && !done_o)
    else $error("block still busy after result");

  // A find result that found a free slot carries no kill, state or schedule information
  a_find_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && free_found_o |->
      kill_status_o == KS_KILLED && !sched_error_o && slot_state_o == ST_READY)
    else $error("find result mixed with other fields");

  // Free slot index is zero unless a free slot was found
  a_free_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !free_found_o |-> free_slot_o == '0)
    else $error("free slot set without free_found");

  // A schedule error only follows a tick or an accepted kill of the current task
  a_err_kill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && sched_error_o |-> kill_status_o == KS_KILLED && !free_found_o)
    else $error("schedule error with refused kill or find");

endmodule

bind round_robin_task_table rrtt_checker u_rrtt_checker (.*);
